// File: rtl/spf_sieve_prime_factorizer_defines.svh
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef SPF_SIEVE_PRIME_FACTORIZER_DEFINES_SVH
`define SPF_SIEVE_PRIME_FACTORIZER_DEFINES_SVH

// pre implies post in the same cycle
`define SPF_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("spf assertion failed");

// pre implies post in the next cycle
`define SPF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spf assertion failed");

`endif

// File: rtl/spf_pkg.sv
`default_nettype none
package spf_pkg;

  localparam int VALUE_W = 16;
  localparam int unsigned VALUE_MAX = (1 << VALUE_W) - 1;
  localparam int DEFAULT_TABLE_DEPTH = 65536;
  localparam int MAX_RESULTS = 6;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W = 3;

  typedef logic [VALUE_W-1:0] value_t;

  localparam value_t VALUE_ONE = value_t'(1);
  localparam value_t LIMIT_RESET = value_t'(VALUE_MAX);

  // register index, taken from paddr[2]
  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    value_t  value;
    status_t kind;
  } job_t;

  // smallest prime factor and the cofactor n / spf(n)
  typedef struct packed {
    value_t spf;
    value_t cof;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   req;
    value_t addr;
  } lookup_t;

endpackage
`default_nettype wire

// File: rtl/spf_in_if.sv
`default_nettype none
interface spf_in_if import spf_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/spf_out_if.sv
`default_nettype none
interface spf_out_if import spf_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  prime;
  logic    last;
  status_t status;

  modport source (output valid, output prime, output last, output status, input ready);
  modport sink (input valid, input prime, input last, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/spf_ram.sv
`default_nettype none
module spf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/spf_front.sv
`default_nettype none
module spf_front import spf_pkg::*; (
  spf_in_if.sink req,
  input  value_t up,
  input  logic   table_ready,
  input  logic   q_full,
  output logic   push,
  output job_t   push_job
);
  assign req.ready = table_ready && !q_full;
  assign push = req.valid && req.ready;

  always_comb begin
    push_job.value = req.value;
    if (req.value <= VALUE_ONE) begin
      push_job.kind = STATUS_NONE;
    end else if (req.value > up) begin
      push_job.kind = STATUS_RANGE;
    end else begin
      push_job.kind = STATUS_OK;
    end
  end
endmodule
`default_nettype wire

// File: rtl/spf_queue.sv
`default_nettype none
`include "spf_sieve_prime_factorizer_defines.svh"
module spf_queue import spf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);
  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [QPTR_W:0]   count_next;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];
  assign count_next = count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `SPF_ASSERT_IMPL(a_no_overflow, push, !full)
  `SPF_ASSERT_IMPL(a_no_underflow, pop, !empty)
endmodule
`default_nettype wire

// File: rtl/spf_table.sv
`default_nettype none
module spf_table import spf_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    rebuild,
  input  value_t  up,
  input  lookup_t lookup,
  output entry_t  rdata,
  output logic    ready
);
  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [6:0] {
    T_CLEAR     = 7'b0000001,
    T_OUTER_RD  = 7'b0000010,
    T_OUTER_CHK = 7'b0000100,
    T_SQ_CHK    = 7'b0001000,
    T_INNER_RD  = 7'b0010000,
    T_INNER_CHK = 7'b0100000,
    T_DONE      = 7'b1000000
  } table_state_t;

  table_state_t           state, state_next;
  logic [VALUE_W:0]       i, i_next;
  logic [VALUE_W:0]       j, j_next;
  value_t                 cof, cof_next;
  value_t                 clr, clr_next;
  logic [2*VALUE_W-1:0]   sq, sq_next;
  logic [VALUE_W:0]       up_w;
  logic                   we;
  logic [AW-1:0]          waddr;
  entry_t                 wdata;
  logic                   sv_re;
  logic [AW-1:0]          sv_raddr;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 rd_entry;

  assign up_w = {1'b0, up};
  assign rd_entry = entry_t'(ram_rdata);
  assign rdata = rd_entry;
  assign ready = (state == T_DONE);
  assign re = ready ? lookup.req : sv_re;
  assign raddr = ready ? AW'(lookup.addr) : sv_raddr;

  always_comb begin
    state_next = state;
    i_next = i;
    j_next = j;
    cof_next = cof;
    clr_next = clr;
    sq_next = sq;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    sv_re = 1'b0;
    sv_raddr = '0;
    case (state)
      T_CLEAR: begin
        we = 1'b1;
        waddr = AW'(clr);
        clr_next = clr + 1'b1;
        if (clr == up) begin
          i_next = (VALUE_W + 1)'(2);
          state_next = T_OUTER_RD;
        end
      end
      T_OUTER_RD: begin
        if (i > up_w) begin
          state_next = T_DONE;
        end else begin
          sv_re = 1'b1;
          sv_raddr = AW'(i);
          state_next = T_OUTER_CHK;
        end
      end
      T_OUTER_CHK: begin
        sq_next = i[VALUE_W-1:0] * i[VALUE_W-1:0];
        if (rd_entry.spf == '0) begin
          we = 1'b1;
          waddr = AW'(i);
          wdata.spf = i[VALUE_W-1:0];
          wdata.cof = VALUE_ONE;
          state_next = T_SQ_CHK;
        end else begin
          i_next = i + 1'b1;
          state_next = T_OUTER_RD;
        end
      end
      T_SQ_CHK: begin
        if (sq > (2 * VALUE_W)'(up)) begin
          i_next = i + 1'b1;
          state_next = T_OUTER_RD;
        end else begin
          j_next = sq[VALUE_W:0];
          cof_next = i[VALUE_W-1:0];
          state_next = T_INNER_RD;
        end
      end
      T_INNER_RD: begin
        if (j > up_w) begin
          i_next = i + 1'b1;
          state_next = T_OUTER_RD;
        end else begin
          sv_re = 1'b1;
          sv_raddr = AW'(j);
          state_next = T_INNER_CHK;
        end
      end
      T_INNER_CHK: begin
        if (rd_entry.spf == '0) begin
          we = 1'b1;
          waddr = AW'(j);
          wdata.spf = i[VALUE_W-1:0];
          wdata.cof = cof;
        end
        j_next = j + i;
        cof_next = cof + 1'b1;
        state_next = T_INNER_RD;
      end
      T_DONE: begin
        state_next = T_DONE;
      end
      default: begin
        state_next = T_CLEAR;
      end
    endcase
    if (rebuild) begin
      state_next = T_CLEAR;
      clr_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLEAR;
      clr <= '0;
    end else begin
      state <= state_next;
      clr <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    cof <= cof_next;
    sq <= sq_next;
  end

  spf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire

// File: rtl/spf_back.sv
`default_nettype none
`include "spf_sieve_prime_factorizer_defines.svh"
module spf_back import spf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  job_t    q_head,
  output logic    pop,
  input  logic    table_ready,
  output lookup_t lookup,
  input  entry_t  rdata,
  spf_out_if.source rsp
);
  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_FIRST = 4'b0010,
    B_STEP  = 4'b0100,
    B_EMIT  = 4'b1000
  } back_state_t;

  back_state_t      state, state_next;
  value_t           p, p_next;
  value_t           pn, pn_next;
  value_t           x, x_next;
  logic [CNT_W-1:0] n, n_next;
  logic             emit_last, emit_last_next;
  logic             out_valid, out_valid_next;
  value_t           out_prime, out_prime_next;
  logic             out_last, out_last_next;
  status_t          out_status, out_status_next;
  logic             out_free;

  assign out_free = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.prime = out_prime;
  assign rsp.last = out_last;
  assign rsp.status = out_status;

  always_comb begin
    state_next = state;
    p_next = p;
    pn_next = pn;
    x_next = x;
    n_next = n;
    emit_last_next = emit_last;
    out_valid_next = out_valid && !rsp.ready;
    out_prime_next = out_prime;
    out_last_next = out_last;
    out_status_next = out_status;
    pop = 1'b0;
    lookup = '0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == STATUS_OK) begin
            pop = 1'b1;
            lookup.req = 1'b1;
            lookup.addr = q_head.value;
            n_next = '0;
            state_next = B_FIRST;
          end else if (out_free) begin
            pop = 1'b1;
            out_valid_next = 1'b1;
            out_prime_next = '0;
            out_last_next = 1'b1;
            out_status_next = q_head.kind;
          end
        end
      end
      B_FIRST: begin
        p_next = rdata.spf;
        if (rdata.cof == VALUE_ONE) begin
          emit_last_next = 1'b1;
          state_next = B_EMIT;
        end else begin
          x_next = rdata.cof;
          lookup.req = 1'b1;
          lookup.addr = rdata.cof;
          state_next = B_STEP;
        end
      end
      B_STEP: begin
        if (rdata.spf == p) begin
          // another power of the same prime: divide it out
          if (rdata.cof == VALUE_ONE) begin
            emit_last_next = 1'b1;
            state_next = B_EMIT;
          end else begin
            x_next = rdata.cof;
            lookup.req = 1'b1;
            lookup.addr = rdata.cof;
          end
        end else begin
          pn_next = rdata.spf;
          x_next = rdata.cof;
          emit_last_next = (n == CNT_W'(MAX_RESULTS - 1));
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_prime_next = p;
          out_last_next = emit_last;
          out_status_next = STATUS_OK;
          n_next = n + 1'b1;
          if (emit_last) begin
            state_next = B_IDLE;
          end else begin
            p_next = pn;
            if (x == VALUE_ONE) begin
              emit_last_next = 1'b1;
            end else begin
              lookup.req = 1'b1;
              lookup.addr = x;
              state_next = B_STEP;
            end
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    pn <= pn_next;
    x <= x_next;
    n <= n_next;
    emit_last <= emit_last_next;
    out_prime <= out_prime_next;
    out_last <= out_last_next;
    out_status <= out_status_next;
  end

  `SPF_ASSERT_IMPL(a_lookup_when_ready, lookup.req, table_ready)
  `SPF_ASSERT_IMPL(a_error_beat_shape, out_valid && out_status != STATUS_OK, out_last && out_prime == '0)
  `SPF_ASSERT_IMPL(a_count_bounded, state == B_EMIT, n < CNT_W'(MAX_RESULTS))
endmodule
`default_nettype wire

// File: rtl/spf_sieve_prime_factorizer.sv
`default_nettype none
// Distinct prime factorizer backed by a smallest-prime-factor table.
// req carries one 16-bit value per beat; rsp returns one beat per distinct
// prime factor in ascending order, last set on the final beat of a value.
// Values 0 and 1 give one beat with status NONE, values above the limit one
// beat with status RANGE; prime is zero on both.
// The limit register sits at APB address 0; a write rebuilds the table.
// After reset or a limit write the table is cleared and sieved up to the
// limit, and req is held not ready for that whole pass.
// Each table entry holds the smallest prime factor and the cofactor, so a
// value is walked by lookups alone, one per prime factor counted with
// multiplicity, and each result beat is emitted from a state of its own.
// Items are processed one at a time by the back end; a 4-entry queue lets
// req keep accepting meanwhile.
// A stalled rsp holds its beat and the back end waits; no beat is dropped.
module spf_sieve_prime_factorizer import spf_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  spf_in_if.sink                req,
  spf_out_if.source             rsp
);
  localparam int unsigned TOP_INT =
    (TABLE_DEPTH - 1 > VALUE_MAX) ? VALUE_MAX : TABLE_DEPTH - 1;
  localparam value_t TOP = value_t'(TOP_INT);

  value_t  limit;
  value_t  up;
  logic    cfg_write;
  logic    table_ready;
  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    q_head;
  lookup_t lookup;
  entry_t  rdata;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_LIMIT);
  assign prdata = (paddr[PADDR_W-1] == REG_LIMIT) ?
                  {{(APB_DATA_W - VALUE_W){1'b0}}, limit} : '0;
  assign up = (limit > TOP) ? TOP : limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit <= pwdata[VALUE_W-1:0];
    end
  end

  spf_front u_front (
    .req         (req),
    .up          (up),
    .table_ready (table_ready),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  spf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  spf_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rebuild (cfg_write),
    .up      (up),
    .lookup  (lookup),
    .rdata   (rdata),
    .ready   (table_ready)
  );

  spf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (pop),
    .table_ready (table_ready),
    .lookup      (lookup),
    .rdata       (rdata),
    .rsp         (rsp)
  );
endmodule
`default_nettype wire

// File: dv/spf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module spf_checker import spf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  value_t                in_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  value_t                out_prime,
  input  logic                  out_last,
  input  status_t               out_status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int unsigned           mismatches,
  output int unsigned           pending,
  output int unsigned           beats_checked
);

  typedef struct packed {
    value_t  prime;
    logic    last;
    status_t status;
  } factor_beat_t;

  factor_beat_t expected_factors[$];
  value_t       table_limit = LIMIT_RESET;
  int unsigned  bad_count = 0;
  int unsigned  beat_count = 0;

  task automatic push_beat(input value_t prime, input logic last, input status_t status);
    factor_beat_t b;
    b.prime  = prime;
    b.last   = last;
    b.status = status;
    expected_factors.insert(expected_factors.size(), b);
  endtask

  // distinct primes in ascending order, by trial division
  task automatic predict_factors(input value_t v);
    int unsigned rest;
    int unsigned p;
    int unsigned found;
    rest  = v;
    p     = 2;
    found = 0;
    if (rest <= 1) begin
      push_beat('0, 1'b1, STATUS_NONE);
    end else if (rest > table_limit) begin
      push_beat('0, 1'b1, STATUS_RANGE);
    end else begin
      while (rest > 1 && found < MAX_RESULTS) begin
        if (p * p > rest) p = rest;
        if (rest % p == 0) begin
          while (rest % p == 0) rest = rest / p;
          found++;
          push_beat(value_t'(p), (rest == 1) || (found == MAX_RESULTS), STATUS_OK);
        end
        p++;
      end
    end
  endtask

  task automatic check_beat();
    factor_beat_t want;
    if (expected_factors.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("unexpected factor beat: prime %0d last %0b status %0d",
                 out_prime, out_last, out_status);
    end else begin
      want = expected_factors.pop_front();
      if (out_prime !== want.prime || out_last !== want.last || out_status !== want.status) begin
        bad_count++;
        if (bad_count <= 10)
          $display({"factor beat mismatch: expected prime %0d last %0b status %0d,",
                    " got prime %0d last %0b status %0d"},
                   want.prime, want.last, want.status, out_prime, out_last, out_status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_factors.delete();
      table_limit = LIMIT_RESET;
      bad_count   = 0;
      beat_count  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT)
        table_limit = pwdata[VALUE_W-1:0];
      if (in_valid && in_ready) predict_factors(in_value);
      if (out_valid && out_ready) begin
        beat_count++;
        check_beat();
      end
    end
    mismatches    <= bad_count;
    pending       <= expected_factors.size();
    beats_checked <= beat_count;
  end

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import spf_pkg::*;

  localparam int WATCHDOG_CYCLES = 2_000_000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 60;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned chk_mismatches;
  int unsigned chk_pending;
  int unsigned chk_beats;
  int unsigned values_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          pace_on = 1'b1;
  bit          rsp_hold_req = 1'b0;

  value_t corners[$] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65535, 16'd65534,
                         16'd65521, 16'd30030, 16'd39270, 16'd43890, 16'd46410,
                         16'd51870, 16'd53130, 16'd60060, 16'd32768, 16'd59049,
                         16'd65025, 16'd21845, 16'd43690, 16'd63001};

  spf_in_if  req_if ();
  spf_out_if rsp_if ();

  spf_sieve_prime_factorizer dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if.sink),
    .rsp     (rsp_if.source)
  );

  spf_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (req_if.valid),
    .in_ready      (req_if.ready),
    .in_value      (req_if.value),
    .out_valid     (rsp_if.valid),
    .out_ready     (rsp_if.ready),
    .out_prime     (rsp_if.prime),
    .out_last      (rsp_if.last),
    .out_status    (rsp_if.status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (chk_mismatches),
    .pending       (chk_pending),
    .beats_checked (chk_beats)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned gap;
    gap = 0;
    if (pace_on) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5, 6, 7: gap = 0;
        15: gap = $urandom_range(12, 40);
        default: gap = $urandom_range(1, 3);
      endcase
    end
    return gap;
  endfunction

  function automatic value_t pick_value(input int unsigned top);
    int unsigned primes [8] = '{2, 3, 5, 7, 11, 13, 251, 257};
    int unsigned prod;
    int unsigned p;
    prod = 1;
    case ($urandom_range(0, 4))
      0: prod = $urandom_range(0, top);
      1: prod = $urandom_range(0, (top < 64) ? top : 64);
      2: begin
        repeat ($urandom_range(1, 8)) begin
          p = primes[$urandom_range(0, 7)];
          if (prod * p <= top) prod = prod * p;
        end
      end
      3: prod = top - $urandom_range(0, (top < 4) ? top : 4);
      default: prod = $urandom_range(0, VALUE_MAX);
    endcase
    return value_t'(prod);
  endfunction

  task automatic send_value(input value_t v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.value <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    values_sent++;
  endtask

  // hold off the sender until every factor beat has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0 || rsp_hold_req);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : rsp_pacer
    int unsigned n;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_hold_req = 1'b0;
      end else if (pace_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("[spf_sieve_prime_factorizer] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned mid_limit;
    int unsigned low_limit;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req_if.valid <= 1'b0;
    req_if.value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (corners[i]) send_value(corners[i]);
    repeat (30) send_value(pick_value(VALUE_MAX));
    drain_results();
    rsp_hold_req = 1'b1;
    repeat (12) send_value(pick_value(VALUE_MAX));
    drain_results();

    apb_write(LIMIT_ADDR, 32'd1);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd2);
    repeat (5) send_value(pick_value(8));
    drain_results();

    apb_write(LIMIT_ADDR, 32'd0);
    send_value(16'd1);
    send_value(16'd2);
    send_value(16'd65535);
    repeat (3) send_value(pick_value(4));
    drain_results();

    mid_limit = $urandom_range(2000, 6000);
    apb_write(LIMIT_ADDR, {16'($urandom), 16'(mid_limit)});
    send_value(value_t'(mid_limit));
    send_value(value_t'(mid_limit + 1));
    repeat (14) send_value(pick_value(mid_limit));
    drain_results();
    apb_write(SPARE_ADDR, $urandom());
    repeat (12) send_value(pick_value(mid_limit));
    drain_results();

    apb_write(LIMIT_ADDR, 32'd2);
    send_value(16'd2);
    send_value(16'd3);
    send_value(16'd4);
    send_value(16'd1);
    send_value(pick_value(VALUE_MAX));
    drain_results();

    low_limit = $urandom_range(100, 999);
    pace_on = 1'b0;
    apb_write(LIMIT_ADDR, 32'(low_limit));
    repeat (20) send_value(pick_value(low_limit));
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d values and %0d factor beats", values_sent, chk_beats);
    $display("limits 65535 (reset), 1, 0, %0d, 2, %0d, plus a spare register write",
             mid_limit, low_limit);
    if (chk_mismatches == 0 && chk_pending == 0) begin
      $display("[spf_sieve_prime_factorizer] OK");
    end else begin
      $display("[spf_sieve_prime_factorizer] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/spf_pkg.sv
rtl/spf_in_if.sv
rtl/spf_out_if.sv
rtl/spf_ram.sv
rtl/spf_front.sv
rtl/spf_queue.sv
rtl/spf_table.sv
rtl/spf_back.sv
rtl/spf_sieve_prime_factorizer.sv
dv/spf_checker.sv
dv/testbench.sv
